// ----- hw/rtl/uft_pkg.sv -----
// Shared types, opcodes and helpers of the UUID feature table.
package uft_pkg;

    localparam int UFT_MAX_ENTRIES = 16;
    localparam int UFT_KEY_W       = 128;
    localparam int UFT_HALF_W      = 64;
    localparam int UFT_BSUM_W      = 12;
    localparam int UFT_SUM_W       = 17;
    localparam int UFT_CNT_OUT_W   = 5;
    localparam int UFT_IDX_W       = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [UFT_HALF_W-1:0]   uuid_high;
        logic [UFT_HALF_W-1:0]   uuid_low;
        logic [UFT_IDX_W-1:0]    entry_index;
    } t_in;

    typedef struct packed {
        logic                     ok;
        logic [UFT_HALF_W-1:0]    read_high;
        logic [UFT_HALF_W-1:0]    read_low;
        logic [UFT_CNT_OUT_W-1:0] count;
        logic [15:0]              byte_sum;
    } t_out;

    // Sum all 16 bytes of a UUID.
    function automatic logic [UFT_BSUM_W-1:0] key_bytes(input logic [UFT_KEY_W-1:0] key);
        logic [UFT_BSUM_W-1:0] s;
        s = '0;
        for (int b = 0; b < UFT_KEY_W / 8; b++) begin
            s = s + UFT_BSUM_W'(key[b*8 +: 8]);
        end
        return s;
    endfunction

endpackage

// ----- hw/rtl/uft_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module uft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/uft_seq.sv -----
// Operation sequencer: searches, appends and compacts the table held in RAM.
module uft_seq import uft_pkg::*; #(
    parameter int  MAX_ENTRIES = UFT_MAX_ENTRIES,
    localparam int CW = $clog2(MAX_ENTRIES + 1),
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int IW = (CW > UFT_IDX_W) ? CW : UFT_IDX_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_in                  i_data,
    output logic                 o_ready,
    output logic                 o_res_valid,
    output t_out                 o_res,
    input  logic                 i_res_ready,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [UFT_KEY_W-1:0] i_rd_data,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [UFT_KEY_W-1:0] o_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_GET,
        S_GETW,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [1:0]            r_op, n_op;
    logic [UFT_KEY_W-1:0]  r_key, n_key;
    logic [UFT_IDX_W-1:0]  r_idx, n_idx;
    logic [UFT_BSUM_W-1:0] r_bsum, n_bsum;
    logic [CW-1:0]         r_count, n_count;
    logic [UFT_SUM_W-1:0]  r_sum, n_sum;
    logic [CW-1:0]         r_issue, n_issue;
    logic                  r_pend, n_pend;
    logic [CW-1:0]         r_pend_addr, n_pend_addr;
    logic                  r_ok, n_ok;
    logic [UFT_KEY_W-1:0]  r_rd, n_rd;

    logic                  hit;
    logic                  more;
    logic [CW-1:0]         shift_dst;
    logic                  idx_ok;

    assign hit       = r_pend && (i_rd_data == r_key);
    assign more      = r_issue < r_count;
    assign shift_dst = r_pend_addr - CW'(1);
    assign idx_ok    = IW'(i_data.entry_index) < IW'(r_count);

    // Next-state and RAM port logic
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_bsum      = r_bsum;
        n_count     = r_count;
        n_sum       = r_sum;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_ok        = r_ok;
        n_rd        = r_rd;
        o_rd_addr   = r_issue[AW-1:0];
        o_wr_en     = 1'b0;
        o_wr_addr   = shift_dst[AW-1:0];
        o_wr_data   = i_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_data.opcode;
                    n_key   = {i_data.uuid_high, i_data.uuid_low};
                    n_idx   = i_data.entry_index;
                    n_bsum  = key_bytes({i_data.uuid_high, i_data.uuid_low});
                    n_issue = '0;
                    n_pend  = 1'b0;
                    n_ok    = 1'b0;
                    n_rd    = '0;
                    case (i_data.opcode)
                        OP_ADD, OP_REMOVE: n_state = S_SCAN;
                        OP_GET:            n_state = idx_ok ? S_GET : S_DONE;
                        default:           n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                // Issue the next read, compare the one issued last cycle
                n_pend      = more;
                n_pend_addr = r_issue;
                if (more) begin
                    n_issue = r_issue + CW'(1);
                end
                if (hit) begin
                    if (r_op == OP_REMOVE) begin
                        n_issue = r_pend_addr + CW'(1);
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (!r_pend && !more) begin
                    // Not present: append on add if there is room
                    if (r_op == OP_ADD && r_count < CW'(MAX_ENTRIES)) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_count[AW-1:0];
                        o_wr_data = r_key;
                        n_count   = r_count + CW'(1);
                        n_sum     = r_sum + UFT_SUM_W'(r_bsum);
                        n_ok      = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // Read entry i+1, write it back to i in the next cycle
                n_pend      = more;
                n_pend_addr = r_issue;
                if (more) begin
                    n_issue = r_issue + CW'(1);
                end
                if (r_pend) begin
                    o_wr_en = 1'b1;
                end
                if (!r_pend && !more) begin
                    n_count = r_count - CW'(1);
                    n_sum   = r_sum - UFT_SUM_W'(r_bsum);
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_GET: begin
                o_rd_addr = r_idx[AW-1:0];
                n_state   = S_GETW;
            end
            S_GETW: begin
                n_ok    = 1'b1;
                n_rd    = i_rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, table counters and the pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_pend  <= 1'b0;
            r_issue <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
            r_issue <= n_issue;
        end
        r_op        <= n_op;
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_bsum      <= n_bsum;
        r_pend_addr <= n_pend_addr;
        r_ok        <= n_ok;
        r_rd        <= n_rd;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.ok        = r_ok;
        o_res.read_high = r_rd[UFT_KEY_W-1:UFT_HALF_W];
        o_res.read_low  = r_rd[UFT_HALF_W-1:0];
        o_res.count     = UFT_CNT_OUT_W'(r_count);
        o_res.byte_sum  = r_sum[15:0];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)
             || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_SCAN || r_state == S_SHIFT))
        else $error("RAM write outside scan or shift");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend) |-> (r_pend_addr < r_count && r_pend_addr != '0))
        else $error("shift moves an entry outside the table");
`endif

endmodule

// ----- hw/rtl/uuid_feature_table_top.sv -----
// Top level of the UUID feature table: RAM, sequencer and output register.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_ready  | i_data (t_in)
//   output  | out       | o_valid / i_ready  | o_data (t_out)
//
// Add scans the table, one entry read per cycle from the single RAM read port.
// Remove scans up to the match at p, then moves each later entry down one slot
// per cycle through the same port. A finished result sits in the output
// register, so the next item is taken while it waits; the sequencer stalls
// only when that register is still full. Synchronous reset empties the table
// (no sweep).
module uuid_feature_table_top import uft_pkg::*; #(
    parameter int MAX_ENTRIES = UFT_MAX_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic                 res_valid;
    logic                 res_ready;
    t_out                 res;
    logic [AW-1:0]        rd_addr;
    logic [UFT_KEY_W-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [UFT_KEY_W-1:0] wr_data;
    logic                 r_valid;
    t_out                 r_data;

    uft_ram #(
        .WIDTH (UFT_KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    uft_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_ready     (o_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Take a new result when the register is empty or being drained
    assign res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_data <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- tb/tb_uuid_feature_table_top.sv -----
// Self-checking testbench of the UUID feature table: directed, random and back-pressure tests.
module tb_uuid_feature_table_top;
    import uft_pkg::*;

    localparam int         TABLE_DEPTH   = UFT_MAX_ENTRIES;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 60;
    localparam int         PHASE_ITEMS   = 250;
    localparam int         MAX_PRINTS    = 100;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    t_in  i_data;
    logic o_ready;
    logic o_valid;
    t_out o_data;
    logic i_ready;

    // Shadow copy of the table contents
    logic [63:0] table_hi [TABLE_DEPTH];
    logic [63:0] table_lo [TABLE_DEPTH];
    int          table_count;
    logic [16:0] table_sum;

    t_out predicted_results [$];
    int   mismatches;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_rx;
    bit   fill_mode;

    uuid_feature_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    function automatic logic [16:0] byte_total(input logic [63:0] half);
        logic [16:0] s;
        s = '0;
        for (int b = 0; b < 8; b++) s = s + 17'(half[b*8 +: 8]);
        return s;
    endfunction

    function automatic int find_key(input logic [63:0] hi, input logic [63:0] lo);
        for (int k = 0; k < table_count; k++) begin
            if (table_hi[k] == hi && table_lo[k] == lo) return k;
        end
        return -1;
    endfunction

    // Apply one operation to the shadow table and return the expected response
    function automatic t_out predict_table_op(input t_in item);
        t_out        res;
        int          pos;
        logic [16:0] key_sum;
        res     = '0;
        pos     = find_key(item.uuid_high, item.uuid_low);
        key_sum = byte_total(item.uuid_high) + byte_total(item.uuid_low);
        case (item.opcode)
            OP_ADD: begin
                if (pos < 0 && table_count < TABLE_DEPTH) begin
                    table_hi[table_count] = item.uuid_high;
                    table_lo[table_count] = item.uuid_low;
                    table_count++;
                    table_sum = table_sum + key_sum;
                    res.ok    = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos >= 0) begin
                    for (int k = pos; k + 1 < table_count; k++) begin
                        table_hi[k] = table_hi[k+1];
                        table_lo[k] = table_lo[k+1];
                    end
                    table_count--;
                    table_sum = table_sum - key_sum;
                    res.ok    = 1'b1;
                end
            end
            OP_GET: begin
                if (int'(item.entry_index) < table_count) begin
                    res.read_high = table_hi[item.entry_index];
                    res.read_low  = table_lo[item.entry_index];
                    res.ok        = 1'b1;
                end
            end
            default: ;
        endcase
        res.count    = 5'(table_count);
        res.byte_sum = table_sum[15:0];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Build a random operation, mostly well-formed against the current table
    function automatic t_in make_item();
        t_in it;
        int  roll;
        int  add_w;
        int  pick;
        it.opcode      = OP_ADD;
        it.uuid_high   = rand64();
        it.uuid_low    = rand64();
        it.entry_index = 8'($urandom_range(255));
        if (table_count >= TABLE_DEPTH) fill_mode = 1'b0;
        else if (table_count == 0) fill_mode = 1'b1;
        pick = (table_count > 0) ? $urandom_range(table_count - 1) : 0;
        if ($urandom_range(99) < 80) begin
            add_w = fill_mode ? 55 : 20;
            roll  = $urandom_range(99);
            if (roll < add_w || table_count == 0 && roll < 75) begin
                // Fresh key, sometimes nearly all ones to push the byte sum up
                if ($urandom_range(9) == 0) begin
                    it.uuid_high = '1;
                    it.uuid_low  = ~(64'd1 << $urandom_range(63));
                end
            end else if (roll < 75) begin
                it.opcode    = OP_REMOVE;
                it.uuid_high = table_hi[pick];
                it.uuid_low  = table_lo[pick];
            end else begin
                it.opcode      = OP_GET;
                it.entry_index = 8'(pick);
            end
        end else begin
            case ($urandom_range(3))
                0: begin
                    // Duplicate add
                    if (table_count > 0) begin
                        it.uuid_high = table_hi[pick];
                        it.uuid_low  = table_lo[pick];
                    end
                end
                1: begin
                    // Remove a near miss of a stored key
                    it.opcode = OP_REMOVE;
                    if (table_count > 0) begin
                        it.uuid_high = table_hi[pick];
                        it.uuid_low  = table_lo[pick];
                        if ($urandom_range(1) == 0)
                            it.uuid_high = it.uuid_high ^ (64'd1 << $urandom_range(63));
                        else
                            it.uuid_low = it.uuid_low ^ (64'd1 << $urandom_range(63));
                    end
                end
                2: it.opcode = OP_GET;
                default: it.opcode = OP_UNUSED;
            endcase
        end
        return it;
    endfunction

    // Offer one item, idling first at random; return at the accepting edge
    task automatic send_item(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted_results.push_back(predict_table_op(item));
    endtask

    task automatic send_op(input logic [1:0] op, input logic [63:0] hi,
                           input logic [63:0] lo, input logic [7:0] idx);
        t_in it;
        it.opcode      = op;
        it.uuid_high   = hi;
        it.uuid_low    = lo;
        it.entry_index = idx;
        send_item(it);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (predicted_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (predicted_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
        end else begin
            want = predicted_results.pop_front();
            if (got.ok !== want.ok)
                report_mismatch($sformatf("ok got %0b want %0b", got.ok, want.ok));
            if (got.read_high !== want.read_high)
                report_mismatch($sformatf("read_high got %h want %h",
                                          got.read_high, want.read_high));
            if (got.read_low !== want.read_low)
                report_mismatch($sformatf("read_low got %h want %h",
                                          got.read_low, want.read_low));
            if (got.count !== want.count)
                report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
            if (got.byte_sum !== want.byte_sum)
                report_mismatch($sformatf("byte_sum got %0d want %0d",
                                          got.byte_sum, want.byte_sum));
        end
    endtask

    // Check each result transfer and drive the receiver's ready
    always @(posedge i_clk) begin
        if (i_rst_n && $isunknown({o_valid, o_ready}))
            report_mismatch("handshake output unknown after reset");
        if (i_rst_n && o_valid && i_ready) check_result(o_data);
        i_ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end

    // Edges of every field, each operation and every failure case
    task automatic test_directed();
        logic [63:0] hi;
        logic [63:0] lo;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(OP_GET, rand64(), rand64(), 8'd0);
        send_op(OP_REMOVE, '0, '0, 8'd0);
        send_op(OP_ADD, '0, '0, 8'd255);
        send_op(OP_ADD, '1, '1, 8'd0);
        send_op(OP_ADD, '1, '1, 8'd0);
        send_op(OP_GET, '0, '0, 8'd1);
        send_op(OP_GET, '1, '1, 8'd2);
        send_op(OP_GET, rand64(), rand64(), 8'd255);
        send_op(OP_UNUSED, '1, '1, 8'd0);
        send_op(OP_REMOVE, '0, '0, 8'd0);
        send_op(OP_GET, '0, '0, 8'd0);
        // Fill the table to capacity
        for (int k = 1; k < TABLE_DEPTH; k++)
            send_op(OP_ADD, 64'h5555_5555_5555_5555 ^ 64'(k), 64'hAAAA_AAAA_AAAA_AAAA, 8'd0);
        send_op(OP_ADD, rand64(), rand64(), 8'd0);
        send_op(OP_GET, '0, '0, 8'(TABLE_DEPTH - 1));
        hi = table_hi[7];
        lo = table_lo[7];
        send_op(OP_REMOVE, hi, lo, 8'd0);
        send_op(OP_GET, '0, '0, 8'd7);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random(input int items, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_item(make_item());
        stop_sending();
        // Pause the sender until every response is back
        wait_drained();
    endtask

    // Hold off the receiver so the block fills and stalls its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_rx <= 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
            begin
                repeat (30) send_item(make_item());
                stop_sending();
            end
        join
        wait_drained();
    endtask

    initial begin
        mismatches     = 0;
        table_count    = 0;
        table_sum      = '0;
        fill_mode      = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_rx        = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        i_ready <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(PHASE_ITEMS, 0, 0);
        test_random(PHASE_ITEMS, 56, 0);
        test_random(PHASE_ITEMS, 0, 56);
        test_random(PHASE_ITEMS, 10, 10);
        test_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/uft_pkg.sv
hw/rtl/uft_ram.sv
hw/rtl/uft_seq.sv
hw/rtl/uuid_feature_table_top.sv
tb/tb_uuid_feature_table_top.sv
